@@ design/clcd_pkg.sv @@
`default_nettype none
package clcd_pkg;

	localparam int COLS = 20;
	localparam int ROWS = 4;
	localparam int DEPTH = ROWS * COLS;
	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(ROWS);

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW = $clog2(OQ_DEPTH);
	localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

	localparam logic [7:0] CMD_MODE_SET = 8'h30;
	localparam logic [7:0] CMD_FUNC_SET = 8'h38;
	localparam logic [7:0] CMD_DISP_OFF = 8'h08;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_ENTRY = 8'h06;
	localparam logic [7:0] CMD_DISP_ON = 8'h0C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [1:0] {
		OP_STEP = 2'd0,
		OP_TICK = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_POWER_UP = 3'd0,
		REG_MODE_SET = 3'd1,
		REG_CLEAR = 3'd2,
		REG_CHAR_WRITE = 3'd3,
		REG_ROW0 = 3'd4,
		REG_ROW1 = 3'd5,
		REG_ROW2 = 3'd6,
		REG_ROW3 = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_UNPLUGGED = 3'd0,
		MODE_INIT = 3'd1,
		MODE_CHAR = 3'd2,
		MODE_LINE0 = 3'd3,
		MODE_LINE1 = 3'd4,
		MODE_LINE2 = 3'd5,
		MODE_LINE3 = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		PH_DONE = 4'd0,
		PH_BEGIN = 4'd1,
		PH_POWER = 4'd2,
		PH_SET1 = 4'd3,
		PH_SET2 = 4'd4,
		PH_FUNC = 4'd5,
		PH_DISPOFF = 4'd6,
		PH_CLEAR = 4'd7,
		PH_ENTRY = 4'd8,
		PH_DISPON = 4'd9
	} phase_t;

	typedef struct packed {
		logic [9:0] power_up_delay;
		logic [9:0] mode_set_delay;
		logic [9:0] clear_delay;
		logic [9:0] char_write_delay;
		logic [3:0][7:0] row_cmd;
	} cfg_t;

	typedef struct packed {
		logic reg_select;
		logic [7:0] lcd_byte;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic [AW-1:0] buf_addr(input logic [RW-1:0] r, input logic [4:0] c);
		buf_addr = AW'(int'(r) * COLS + int'(c));
	endfunction

endpackage
`default_nettype wire

@@ design/clcd_regs.sv @@
`default_nettype none
module clcd_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output clcd_pkg::cfg_t cfg
);

	clcd_pkg::cfg_t cfg_q;
	clcd_pkg::reg_idx_t idx;
	logic wr;

	assign idx = clcd_pkg::reg_idx_t'(paddr[4:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up_delay <= 10'd250;
			cfg_q.mode_set_delay <= 10'd5;
			cfg_q.clear_delay <= 10'd2;
			cfg_q.char_write_delay <= 10'd2;
			cfg_q.row_cmd[0] <= 8'd128;
			cfg_q.row_cmd[1] <= 8'd192;
			cfg_q.row_cmd[2] <= 8'd148;
			cfg_q.row_cmd[3] <= 8'd212;
		end else if (wr) begin
			unique case (idx)
				clcd_pkg::REG_POWER_UP: cfg_q.power_up_delay <= pwdata[9:0];
				clcd_pkg::REG_MODE_SET: cfg_q.mode_set_delay <= pwdata[9:0];
				clcd_pkg::REG_CLEAR: cfg_q.clear_delay <= pwdata[9:0];
				clcd_pkg::REG_CHAR_WRITE: cfg_q.char_write_delay <= pwdata[9:0];
				clcd_pkg::REG_ROW0: cfg_q.row_cmd[0] <= pwdata[7:0];
				clcd_pkg::REG_ROW1: cfg_q.row_cmd[1] <= pwdata[7:0];
				clcd_pkg::REG_ROW2: cfg_q.row_cmd[2] <= pwdata[7:0];
				clcd_pkg::REG_ROW3: cfg_q.row_cmd[3] <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			clcd_pkg::REG_POWER_UP: prdata = {22'd0, cfg_q.power_up_delay};
			clcd_pkg::REG_MODE_SET: prdata = {22'd0, cfg_q.mode_set_delay};
			clcd_pkg::REG_CLEAR: prdata = {22'd0, cfg_q.clear_delay};
			clcd_pkg::REG_CHAR_WRITE: prdata = {22'd0, cfg_q.char_write_delay};
			clcd_pkg::REG_ROW0: prdata = {24'd0, cfg_q.row_cmd[0]};
			clcd_pkg::REG_ROW1: prdata = {24'd0, cfg_q.row_cmd[1]};
			clcd_pkg::REG_ROW2: prdata = {24'd0, cfg_q.row_cmd[2]};
			clcd_pkg::REG_ROW3: prdata = {24'd0, cfg_q.row_cmd[3]};
		endcase
	end

endmodule
`default_nettype wire

@@ design/clcd_outq.sv @@
`default_nettype none
module clcd_outq (
	input wire logic clk,
	input wire logic arst_n,
	input wire clcd_pkg::push_t push,
	output logic room,
	output logic result_valid,
	input wire logic result_stall,
	output clcd_pkg::result_t head
);

	clcd_pkg::result_t ent_q [clcd_pkg::OQ_DEPTH];
	logic [clcd_pkg::OQ_PW-1:0] wp_q;
	logic [clcd_pkg::OQ_PW-1:0] rp_q;
	logic [clcd_pkg::OQ_CW-1:0] cnt_q;
	logic pop;

	assign result_valid = (cnt_q != '0);
	assign pop = result_valid && !result_stall;
	assign room = (cnt_q <= clcd_pkg::OQ_CW'(clcd_pkg::OQ_DEPTH - 2));
	assign head = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + clcd_pkg::OQ_PW'(push.n);
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + clcd_pkg::OQ_CW'(push.n) - clcd_pkg::OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[wp_q + 1'b1] <= push.r1;
		end
	end

endmodule
`default_nettype wire

@@ design/clcd_ctrl.sv @@
`default_nettype none
module clcd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire clcd_pkg::cfg_t cfg,
	input wire logic item_valid,
	output logic item_stall,
	input wire logic [1:0] op,
	input wire logic module_present,
	input wire logic [2:0] row,
	input wire logic [4:0] col,
	input wire logic [7:0] char_code,
	input wire logic room,
	output clcd_pkg::push_t push
);

	logic valid_s1;
	logic [1:0] op_s1;
	logic present_s1;
	logic [2:0] row_s1;
	logic [4:0] col_s1;
	logic [7:0] char_s1;

	clcd_pkg::mode_t mode_q, mode_n;
	clcd_pkg::phase_t phase_q, phase_n;
	logic [9:0] timer_q, timer_n;
	logic [clcd_pkg::RW-1:0] rrow_q, rrow_n;
	logic [4:0] rcol_q, rcol_n;
	logic [7:0] cur_q;

	logic [7:0] mem [clcd_pkg::DEPTH];
	logic [clcd_pkg::DEPTH-1:0] vld_q;

	logic fire;
	logic expired;
	logic wr_en;
	logic [clcd_pkg::AW-1:0] wr_addr;
	logic [clcd_pkg::AW-1:0] rd_addr;
	logic [5:0] col_inc;
	logic [1:0] cnt;
	clcd_pkg::result_t res [2];

	assign item_stall = valid_s1 && !room;
	assign fire = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1 <= op;
			present_s1 <= module_present;
			row_s1 <= row;
			col_s1 <= col;
			char_s1 <= char_code;
		end
	end

	assign wr_en = fire && (clcd_pkg::op_t'(op_s1) == clcd_pkg::OP_WRITE)
		&& (int'(row_s1) < clcd_pkg::ROWS) && (int'(col_s1) < clcd_pkg::COLS);
	assign wr_addr = clcd_pkg::buf_addr(row_s1[clcd_pkg::RW-1:0], col_s1);
	assign rd_addr = clcd_pkg::buf_addr(rrow_n, rcol_n);
	assign col_inc = {1'b0, rcol_q} + 6'd1;

	always_comb begin
		mode_n = mode_q;
		phase_n = phase_q;
		timer_n = timer_q;
		rrow_n = rrow_q;
		rcol_n = rcol_q;
		cnt = 2'd0;
		res[0] = '0;
		res[1] = '0;
		expired = (timer_q == 10'd0);
		if (fire) begin
			unique case (clcd_pkg::op_t'(op_s1))
				clcd_pkg::OP_TICK: begin
					if (timer_q != 10'd0) begin
						timer_n = timer_q - 10'd1;
					end
				end
				clcd_pkg::OP_STEP: begin
					unique case (phase_q)
						clcd_pkg::PH_BEGIN: begin
							phase_n = clcd_pkg::PH_POWER;
							timer_n = cfg.power_up_delay;
						end
						clcd_pkg::PH_POWER: begin
							if (expired) begin
								res[cnt[0]] = '{1'b0, clcd_pkg::CMD_MODE_SET, 1'b0};
								cnt = cnt + 2'd1;
								phase_n = clcd_pkg::PH_SET1;
								timer_n = cfg.mode_set_delay;
							end
						end
						clcd_pkg::PH_SET1: begin
							if (expired) begin
								res[cnt[0]] = '{1'b0, clcd_pkg::CMD_MODE_SET, 1'b0};
								cnt = cnt + 2'd1;
								phase_n = clcd_pkg::PH_SET2;
								timer_n = cfg.mode_set_delay;
							end
						end
						clcd_pkg::PH_SET2: begin
							if (expired) begin
								res[cnt[0]] = '{1'b0, clcd_pkg::CMD_MODE_SET, 1'b0};
								cnt = cnt + 2'd1;
								phase_n = clcd_pkg::PH_FUNC;
							end
						end
						clcd_pkg::PH_FUNC: begin
							res[cnt[0]] = '{1'b0, clcd_pkg::CMD_FUNC_SET, 1'b0};
							cnt = cnt + 2'd1;
							phase_n = clcd_pkg::PH_DISPOFF;
						end
						clcd_pkg::PH_DISPOFF: begin
							res[cnt[0]] = '{1'b0, clcd_pkg::CMD_DISP_OFF, 1'b0};
							cnt = cnt + 2'd1;
							phase_n = clcd_pkg::PH_CLEAR;
						end
						clcd_pkg::PH_CLEAR: begin
							res[cnt[0]] = '{1'b0, clcd_pkg::CMD_CLEAR, 1'b0};
							cnt = cnt + 2'd1;
							phase_n = clcd_pkg::PH_ENTRY;
							timer_n = cfg.clear_delay;
						end
						clcd_pkg::PH_ENTRY: begin
							if (expired) begin
								res[cnt[0]] = '{1'b0, clcd_pkg::CMD_ENTRY, 1'b0};
								cnt = cnt + 2'd1;
								phase_n = clcd_pkg::PH_DISPON;
								timer_n = cfg.clear_delay;
							end
						end
						clcd_pkg::PH_DISPON: begin
							if (expired) begin
								res[cnt[0]] = '{1'b0, clcd_pkg::CMD_DISP_ON, 1'b0};
								cnt = cnt + 2'd1;
								phase_n = clcd_pkg::PH_DONE;
							end
						end
						default: phase_n = clcd_pkg::PH_DONE;
					endcase

					unique case (mode_q)
						clcd_pkg::MODE_UNPLUGGED: begin
							if (present_s1) begin
								phase_n = clcd_pkg::PH_BEGIN;
								mode_n = clcd_pkg::MODE_INIT;
								timer_n = 10'd0;
							end
						end
						clcd_pkg::MODE_INIT: begin
							if (!present_s1) begin
								phase_n = clcd_pkg::PH_DONE;
								mode_n = clcd_pkg::MODE_UNPLUGGED;
								timer_n = 10'd0;
							end else if (phase_n == clcd_pkg::PH_DONE) begin
								res[cnt[0]] = '{1'b0, cfg.row_cmd[0], 1'b0};
								cnt = cnt + 2'd1;
								rrow_n = '0;
								rcol_n = '0;
								mode_n = clcd_pkg::MODE_CHAR;
								timer_n = cfg.char_write_delay;
							end
						end
						clcd_pkg::MODE_CHAR: begin
							if (!present_s1) begin
								mode_n = clcd_pkg::MODE_UNPLUGGED;
								timer_n = 10'd0;
							end else if (timer_n == 10'd0) begin
								res[cnt[0]] = '{1'b1, cur_q, 1'b0};
								cnt = cnt + 2'd1;
								if (col_inc >= 6'(clcd_pkg::COLS)) begin
									rcol_n = '0;
									rrow_n = rrow_q + 1'b1;
									timer_n = 10'd0;
									unique case (rrow_n)
										2'd0: mode_n = clcd_pkg::MODE_LINE0;
										2'd1: mode_n = clcd_pkg::MODE_LINE1;
										2'd2: mode_n = clcd_pkg::MODE_LINE2;
										2'd3: mode_n = clcd_pkg::MODE_LINE3;
									endcase
								end else begin
									rcol_n = col_inc[4:0];
									timer_n = cfg.char_write_delay;
								end
							end
						end
						clcd_pkg::MODE_LINE0, clcd_pkg::MODE_LINE1,
						clcd_pkg::MODE_LINE2, clcd_pkg::MODE_LINE3: begin
							unique case (mode_q)
								clcd_pkg::MODE_LINE0: res[cnt[0]] = '{1'b0, cfg.row_cmd[0], 1'b0};
								clcd_pkg::MODE_LINE1: res[cnt[0]] = '{1'b0, cfg.row_cmd[1], 1'b0};
								clcd_pkg::MODE_LINE2: res[cnt[0]] = '{1'b0, cfg.row_cmd[2], 1'b0};
								default: res[cnt[0]] = '{1'b0, cfg.row_cmd[3], 1'b0};
							endcase
							cnt = cnt + 2'd1;
							mode_n = clcd_pkg::MODE_CHAR;
							timer_n = cfg.char_write_delay;
						end
						default: mode_n = clcd_pkg::MODE_UNPLUGGED;
					endcase

					if (cnt == 2'd2) begin
						res[1].last = 1'b1;
					end else if (cnt == 2'd1) begin
						res[0].last = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign push = '{cnt, res[0], res[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= clcd_pkg::MODE_UNPLUGGED;
			phase_q <= clcd_pkg::PH_DONE;
			timer_q <= '0;
			rrow_q <= '0;
			rcol_q <= '0;
			vld_q <= '0;
			cur_q <= clcd_pkg::CHAR_SPACE;
		end else begin
			mode_q <= mode_n;
			phase_q <= phase_n;
			timer_q <= timer_n;
			rrow_q <= rrow_n;
			rcol_q <= rcol_n;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (wr_en && (wr_addr == rd_addr)) begin
				cur_q <= char_s1;
			end else if (vld_q[rd_addr]) begin
				cur_q <= mem[rd_addr];
			end else begin
				cur_q <= clcd_pkg::CHAR_SPACE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= char_s1;
		end
	end

endmodule
`default_nettype wire

@@ design/char_lcd_refresh_controller.sv @@
// Flow: an accepted transaction is registered in the input stage, then processed once the output
// queue has room; its results are written into that queue, whose head is offered on the result channel.
// Throughput: one transaction per cycle while the output queue has room; a step that emits two bytes
// queues both in order; the input stalls when the four-entry output queue lacks room for two results.
// Reset: asynchronous, active low; the character buffer reads as spaces through per-entry
// valid flags, so no clearing pass is needed and transactions are taken right after reset.
`default_nettype none
module char_lcd_refresh_controller (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic item_valid,
	output logic item_stall,
	input wire logic [1:0] op,
	input wire logic module_present,
	input wire logic [2:0] row,
	input wire logic [4:0] col,
	input wire logic [7:0] char_code,
	output logic result_valid,
	input wire logic result_stall,
	output logic reg_select,
	output logic [7:0] lcd_byte,
	output logic last
);

	clcd_pkg::cfg_t cfg;
	clcd_pkg::push_t push;
	clcd_pkg::result_t head;
	logic room;

	clcd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	clcd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.module_present(module_present),
		.row(row),
		.col(col),
		.char_code(char_code),
		.room(room),
		.push(push)
	);

	clcd_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.head(head)
	);

	assign reg_select = head.reg_select;
	assign lcd_byte = head.lcd_byte;
	assign last = head.last;

endmodule
`default_nettype wire

@@ sim/char_lcd_refresh_controller_tb.sv @@
`timescale 1ns / 100ps
module char_lcd_refresh_controller_tb;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam clcd_pkg::result_t NO_BYTE = '0;

	localparam clcd_pkg::cfg_t DIR_CFG = '{power_up_delay: 10'd0, mode_set_delay: 10'd0,
		clear_delay: 10'd0, char_write_delay: 10'd0,
		row_cmd: {8'hD4, 8'h94, 8'hC0, 8'h80}};
	localparam clcd_pkg::cfg_t MAX_CFG = '{power_up_delay: 10'd1023, mode_set_delay: 10'd1023,
		clear_delay: 10'd1023, char_write_delay: 10'd1023,
		row_cmd: {8'hFF, 8'h00, 8'hFF, 8'h00}};
	localparam clcd_pkg::cfg_t FAST_CFG = '{power_up_delay: 10'd1, mode_set_delay: 10'd1,
		clear_delay: 10'd1, char_write_delay: 10'd0,
		row_cmd: {8'h00, 8'hFF, 8'h00, 8'hFF}};

	typedef struct packed {
		clcd_pkg::op_t op;
		logic present;
		logic [2:0] row;
		logic [4:0] col;
		logic [7:0] ch;
		logic typed;
		logic [1:0] nres;
		clcd_pkg::result_t r0;
		clcd_pkg::result_t r1;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic item_valid;
	logic item_stall;
	logic [1:0] op;
	logic module_present;
	logic [2:0] row;
	logic [4:0] col;
	logic [7:0] char_code;
	logic result_valid;
	logic result_stall;
	logic reg_select;
	logic [7:0] lcd_byte;
	logic last;

	clcd_pkg::cfg_t setting;
	clcd_pkg::mode_t mode;
	clcd_pkg::phase_t phase;
	logic [9:0] timer;
	logic [1:0] scan_row;
	logic [4:0] scan_col;
	logic [7:0] screen [clcd_pkg::DEPTH];
	clcd_pkg::result_t emitted [$];
	clcd_pkg::result_t lcd_expect [$];
	clcd_pkg::result_t want;
	probe_t plan [26];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_kind = 0;

	char_lcd_refresh_controller dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic clcd_pkg::result_t lcd_res(logic rs, logic [7:0] b, logic fin);
		return clcd_pkg::result_t'{rs, b, fin};
	endfunction

	function automatic void emit_byte(logic rs, logic [7:0] b);
		emitted.push_back(lcd_res(rs, b, 1'b0));
	endfunction

	function automatic void predict_lcd_bytes(clcd_pkg::op_t f_op, logic f_present,
		logic [2:0] f_row, logic [4:0] f_col, logic [7:0] f_ch);
		logic expired;
		emitted.delete();
		case (f_op)
			clcd_pkg::OP_TICK: begin
				if (timer != 0)
					timer = timer - 10'd1;
			end
			clcd_pkg::OP_WRITE: begin
				if (f_row < clcd_pkg::ROWS && f_col < clcd_pkg::COLS)
					screen[int'(f_row) * clcd_pkg::COLS + int'(f_col)] = f_ch;
			end
			clcd_pkg::OP_STEP: begin
				expired = (timer == 0);
				case (phase)
					clcd_pkg::PH_BEGIN: begin
						phase = clcd_pkg::PH_POWER;
						timer = setting.power_up_delay;
					end
					clcd_pkg::PH_POWER: if (expired) begin
						emit_byte(1'b0, clcd_pkg::CMD_MODE_SET);
						phase = clcd_pkg::PH_SET1;
						timer = setting.mode_set_delay;
					end
					clcd_pkg::PH_SET1: if (expired) begin
						emit_byte(1'b0, clcd_pkg::CMD_MODE_SET);
						phase = clcd_pkg::PH_SET2;
						timer = setting.mode_set_delay;
					end
					clcd_pkg::PH_SET2: if (expired) begin
						emit_byte(1'b0, clcd_pkg::CMD_MODE_SET);
						phase = clcd_pkg::PH_FUNC;
					end
					clcd_pkg::PH_FUNC: begin
						emit_byte(1'b0, clcd_pkg::CMD_FUNC_SET);
						phase = clcd_pkg::PH_DISPOFF;
					end
					clcd_pkg::PH_DISPOFF: begin
						emit_byte(1'b0, clcd_pkg::CMD_DISP_OFF);
						phase = clcd_pkg::PH_CLEAR;
					end
					clcd_pkg::PH_CLEAR: begin
						emit_byte(1'b0, clcd_pkg::CMD_CLEAR);
						phase = clcd_pkg::PH_ENTRY;
						timer = setting.clear_delay;
					end
					clcd_pkg::PH_ENTRY: if (expired) begin
						emit_byte(1'b0, clcd_pkg::CMD_ENTRY);
						phase = clcd_pkg::PH_DISPON;
						timer = setting.clear_delay;
					end
					clcd_pkg::PH_DISPON: if (expired) begin
						emit_byte(1'b0, clcd_pkg::CMD_DISP_ON);
						phase = clcd_pkg::PH_DONE;
					end
					default: phase = clcd_pkg::PH_DONE;
				endcase
				case (mode)
					clcd_pkg::MODE_UNPLUGGED: if (f_present) begin
						phase = clcd_pkg::PH_BEGIN;
						mode = clcd_pkg::MODE_INIT;
						timer = '0;
					end
					clcd_pkg::MODE_INIT: begin
						if (!f_present) begin
							phase = clcd_pkg::PH_DONE;
							mode = clcd_pkg::MODE_UNPLUGGED;
							timer = '0;
						end else if (phase == clcd_pkg::PH_DONE) begin
							emit_byte(1'b0, setting.row_cmd[0]);
							scan_row = '0;
							scan_col = '0;
							mode = clcd_pkg::MODE_CHAR;
							timer = setting.char_write_delay;
						end
					end
					clcd_pkg::MODE_CHAR: begin
						if (!f_present) begin
							mode = clcd_pkg::MODE_UNPLUGGED;
							timer = '0;
						end else if (timer == 0) begin
							emit_byte(1'b1,
								screen[int'(scan_row) * clcd_pkg::COLS + int'(scan_col)]);
							if (scan_col == clcd_pkg::COLS - 1) begin
								scan_col = '0;
								scan_row = scan_row + 2'd1;
								mode = clcd_pkg::mode_t'(int'(clcd_pkg::MODE_LINE0)
									+ int'(scan_row));
								timer = '0;
							end else begin
								scan_col = scan_col + 5'd1;
								timer = setting.char_write_delay;
							end
						end
					end
					clcd_pkg::MODE_LINE0, clcd_pkg::MODE_LINE1, clcd_pkg::MODE_LINE2,
					clcd_pkg::MODE_LINE3: begin
						emit_byte(1'b0,
							setting.row_cmd[int'(mode) - int'(clcd_pkg::MODE_LINE0)]);
						mode = clcd_pkg::MODE_CHAR;
						timer = setting.char_write_delay;
					end
					default: mode = clcd_pkg::MODE_UNPLUGGED;
				endcase
				if (emitted.size() != 0)
					emitted[emitted.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(clcd_pkg::op_t f_op, logic f_present, logic [2:0] f_row,
		logic [4:0] f_col, logic [7:0] f_ch, logic typed = 1'b0, logic [1:0] nres = 2'd0,
		clcd_pkg::result_t r0 = '0, clcd_pkg::result_t r1 = '0);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		op <= f_op;
		module_present <= f_present;
		row <= f_row;
		col <= f_col;
		char_code <= f_ch;
		do @(posedge clk); while (item_stall);
		predict_lcd_bytes(f_op, f_present, f_row, f_col, f_ch);
		if (typed) begin
			if (nres > 0)
				lcd_expect.push_back(r0);
			if (nres > 1)
				lcd_expect.push_back(r1);
		end else begin
			foreach (emitted[i])
				lcd_expect.push_back(emitted[i]);
		end
		@(negedge clk);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (lcd_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(clcd_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(clcd_pkg::cfg_t s);
		settle();
		setting = s;
		apb_write(clcd_pkg::REG_POWER_UP, 32'(s.power_up_delay));
		apb_write(clcd_pkg::REG_MODE_SET, 32'(s.mode_set_delay));
		apb_write(clcd_pkg::REG_CLEAR, 32'(s.clear_delay));
		apb_write(clcd_pkg::REG_CHAR_WRITE, 32'(s.char_write_delay));
		for (int i = 0; i < clcd_pkg::ROWS; i++)
			apb_write(clcd_pkg::reg_idx_t'(int'(clcd_pkg::REG_ROW0) + i), 32'(s.row_cmd[i]));
	endtask

	function automatic clcd_pkg::cfg_t random_settings(int max_delay, int max_power);
		clcd_pkg::cfg_t s;
		s.power_up_delay = 10'($urandom_range(0, max_power));
		s.mode_set_delay = 10'($urandom_range(0, max_delay));
		s.clear_delay = 10'($urandom_range(0, max_delay));
		s.char_write_delay = 10'($urandom_range(0, max_delay));
		for (int i = 0; i < clcd_pkg::ROWS; i++)
			s.row_cmd[i] = 8'($urandom);
		return s;
	endfunction

	task automatic run_random(int decisions, int unplug_pct, int max_ticks);
		int sel;
		int ticks;
		logic [2:0] r;
		logic [4:0] c;
		repeat (decisions) begin
			sel = $urandom_range(0, 99);
			if (timer != 0 && (sel < 8 || (timer > 60 && sel < 40))) begin
				// drain the delay, sometimes stopping one short
				ticks = ($urandom_range(0, 3) == 0) ? int'(timer) - 1 : int'(timer);
				if (ticks > max_ticks)
					ticks = max_ticks;
				repeat (ticks)
					send_item(clcd_pkg::OP_TICK, 1'($urandom), 3'($urandom), 5'($urandom),
						8'($urandom));
			end else if (sel < 60) begin
				send_item(clcd_pkg::OP_STEP, 1'($urandom_range(0, 99) >= unplug_pct),
					3'($urandom), 5'($urandom), 8'($urandom));
			end else if (sel < 75) begin
				send_item(clcd_pkg::OP_TICK, 1'($urandom), 3'($urandom), 5'($urandom),
					8'($urandom));
			end else if (sel < 93) begin
				if ($urandom_range(0, 4) == 0) begin
					r = 3'($urandom);
					c = 5'($urandom);
				end else begin
					r = 3'($urandom_range(0, clcd_pkg::ROWS - 1));
					c = 5'($urandom_range(0, clcd_pkg::COLS - 1));
				end
				send_item(clcd_pkg::OP_WRITE, 1'($urandom), r, c, 8'($urandom));
			end else begin
				send_item(clcd_pkg::OP_NONE, 1'($urandom), 3'($urandom), 5'($urandom),
					8'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_kind = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_kind)
			0: result_stall <= 1'b0;
			1: result_stall <= 1'($urandom);
			default: result_stall <= (stall_left % 7) < 3;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (lcd_expect.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected lcd byte: rs=%0d byte=%02h last=%0d",
						reg_select, lcd_byte, last);
			end else begin
				want = lcd_expect.pop_front();
				if (reg_select !== want.reg_select || lcd_byte !== want.lcd_byte ||
					last !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("lcd byte mismatch: exp rs=%0d byte=%02h last=%0d %s",
							want.reg_select, want.lcd_byte, want.last,
							$sformatf("got rs=%0d byte=%02h last=%0d",
								reg_select, lcd_byte, last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("char_lcd_refresh_controller_tb failed");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		op = clcd_pkg::OP_STEP;
		module_present = 1'b0;
		row = '0;
		col = '0;
		char_code = '0;
		result_stall = 1'b0;
		setting = DIR_CFG;
		mode = clcd_pkg::MODE_UNPLUGGED;
		phase = clcd_pkg::PH_DONE;
		timer = '0;
		scan_row = '0;
		scan_col = '0;
		foreach (screen[i])
			screen[i] = clcd_pkg::CHAR_SPACE;
		plan = '{
			'{clcd_pkg::OP_STEP, 1'b0, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_NONE, 1'b1, 3'd7, 5'd31, 8'hFF, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_WRITE, 1'b1, 3'd7, 5'd31, 8'hFF, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_WRITE, 1'b0, 3'd0, 5'd20, 8'h41, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_WRITE, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_WRITE, 1'b0, 3'd3, 5'd19, 8'hFF, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_WRITE, 1'b1, 3'd4, 5'd0, 8'h55, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_TICK, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b0, clcd_pkg::CMD_MODE_SET, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_TICK, 1'b0, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b0, clcd_pkg::CMD_MODE_SET, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b0, clcd_pkg::CMD_MODE_SET, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b0, clcd_pkg::CMD_FUNC_SET, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b0, clcd_pkg::CMD_DISP_OFF, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b0, clcd_pkg::CMD_CLEAR, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b0, clcd_pkg::CMD_ENTRY, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd2,
				lcd_res(1'b0, clcd_pkg::CMD_DISP_ON, 1'b0),
				lcd_res(1'b0, DIR_CFG.row_cmd[0], 1'b1)},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd1,
				lcd_res(1'b1, 8'h00, 1'b1), NO_BYTE},
			'{clcd_pkg::OP_WRITE, 1'b1, 3'd0, 5'd2, 8'h7E, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b0, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b0, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b1, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE},
			'{clcd_pkg::OP_STEP, 1'b0, 3'd0, 5'd0, 8'h00, 1'b1, 2'd0, NO_BYTE, NO_BYTE}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		apply_settings(DIR_CFG);
		foreach (plan[i])
			send_item(plan[i].op, plan[i].present, plan[i].row, plan[i].col, plan[i].ch,
				plan[i].typed, plan[i].nres, plan[i].r0, plan[i].r1);
		apply_settings(random_settings(3, 3));
		run_random(100, 2, 1023);
		apply_settings(MAX_CFG);
		run_random(16, 1, 12);
		// unplug to drop the long delay
		repeat (2)
			send_item(clcd_pkg::OP_STEP, 1'b0, 3'd0, 5'd0, 8'h00);
		apply_settings(FAST_CFG);
		run_random(110, 0, 1023);
		apply_settings(random_settings(6, 20));
		run_random(80, 3, 1023);
		settle();
		if (errors == 0 && lcd_expect.size() == 0)
			$display("char_lcd_refresh_controller_tb passed");
		else
			$display("char_lcd_refresh_controller_tb failed");
		$finish;
	end

endmodule
